// ===== design/mm_pkg.sv =====
`timescale 1ns / 1ps

package mm_pkg;

  // element, sum and position widths
  localparam int ELEM_W      = 16;
  localparam int SUM_W       = 35;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int IDX_W       = 6;
  localparam int POS_W       = 3;
  localparam int DIM_W       = 4;
  localparam int STORE_DEPTH = 64;
  localparam int CFG_IDX_W   = 2;

  localparam int DEFAULT_MAX_DIM = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 2'd3;

  // request operations
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        index;
    logic signed [ELEM_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] result;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic                    last;
    logic                    shape_error;
  } res_t;

endpackage

// ===== design/mm_stream_if.sv =====
`timescale 1ns / 1ps

interface mm_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== design/matrix_multiply_core.sv =====
`timescale 1ns / 1ps

// Dense matrix product C = A * B over signed Q8.8 elements, exact Q19.16 sums.
// Request channel (req): load-A and load-B requests write one element at a
// flat row-major index; a run request emits every element of C in row-major
// order on the result channel (res), tagged with row, column, last and
// shape_error. Dimensions come from the write port (cfg_we, cfg_addr,
// cfg_data); the user must write them only while the block is idle; the block
// itself does not enforce this. A run uses one shared multiply-accumulate fed
// by one read port per store, so it issues one product term per cycle unless
// res stalls: rows_a * cols_b * inner_a terms, or rows_a * cols_b terms on a
// shape mismatch (results are then zero). Terms pass the store read, product
// and accumulate; a new request is taken the cycle after a run's last term issues.
// The pipeline (read, multiply, accumulate, output register) stalls as a
// whole while a result waits on a low res.ready, so nothing is dropped.
// Reset sets all four dimensions to MAX_DIM and empties the pipeline; the
// element stores are not cleared and hold garbage until written.
module matrix_multiply_core #(
  parameter int MAX_DIM = mm_pkg::DEFAULT_MAX_DIM
) (
  input  logic                             clk,
  input  logic                             rst,
  mm_stream_if.sink                        req,
  mm_stream_if.source                      res,
  input  logic                             cfg_we,
  input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [mm_pkg::DIM_W-1:0]         cfg_data
);

  import mm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             first;
    logic             last_k;
    logic             last;
    logic             err;
  } tag_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = v;
    return r;
  endfunction

  // configuration registers
  logic [DIM_W-1:0] rows_a, inner_a, rows_b, cols_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a  <= DIM_W'(MAX_DIM);
      inner_a <= DIM_W'(MAX_DIM);
      rows_b  <= DIM_W'(MAX_DIM);
      cols_b  <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROWS_A:  rows_a  <= cfg_data;
        REG_INNER_A: inner_a <= cfg_data;
        REG_ROWS_B:  rows_b  <= cfg_data;
        REG_COLS_B:  cols_b  <= cfg_data;
        default:     ;
      endcase
    end
  end

  // pipeline advance: output register free or being taken
  logic   res_valid;
  res_t   res_q;
  logic   adv;
  assign adv = !res_valid || res.ready;

  state_t state;
  logic   req_fire;
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // sequencer registers
  logic [DIM_W-1:0] ra, ia, cb;
  logic             err;
  logic [POS_W-1:0] r, c, k;
  logic [IDX_W-1:0] a_base, b_ptr;

  logic [IDX_W-1:0] a_addr;
  logic             issue, last_k, last_elem;
  tag_t             tag0;

  assign a_addr    = a_base + IDX_W'(k);
  assign issue     = (state == ST_RUN) && adv;
  assign last_k    = err || ({1'b0, k} == ia - DIM_W'(1));
  assign last_elem = ({1'b0, r} == ra - DIM_W'(1)) && ({1'b0, c} == cb - DIM_W'(1));

  always_comb begin
    tag0.row    = r;
    tag0.col    = c;
    tag0.first  = (k == '0);
    tag0.last_k = last_k;
    tag0.last   = last_elem;
    tag0.err    = err;
  end

  // run sequencer: walks row, column and inner index
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req_fire && req.payload.op == OP_RUN) begin
            ra     <= eff_dim(rows_a);
            ia     <= eff_dim(inner_a);
            cb     <= eff_dim(cols_b);
            err    <= eff_dim(rows_b) != eff_dim(inner_a);
            r      <= '0;
            c      <= '0;
            k      <= '0;
            a_base <= '0;
            b_ptr  <= '0;
            state  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (adv) begin
            if (!last_k) begin
              k     <= k + POS_W'(1);
              b_ptr <= b_ptr + IDX_W'(cb);
            end else begin
              k <= '0;
              if ({1'b0, c} == cb - DIM_W'(1)) begin
                c      <= '0;
                r      <= r + POS_W'(1);
                a_base <= a_base + IDX_W'(ia);
                b_ptr  <= '0;
              end else begin
                c     <= c + POS_W'(1);
                b_ptr <= IDX_W'(c) + IDX_W'(1);
              end
              if (last_elem) state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // element stores: one write port from loads, one registered read port each
  logic signed [ELEM_W-1:0] left_mem  [STORE_DEPTH];
  logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];
  logic signed [ELEM_W-1:0] a_q, b_q;

  always_ff @(posedge clk) begin
    if (req_fire && req.payload.op == OP_LOAD_A) left_mem[req.payload.index] <= req.payload.value;
    if (adv) a_q <= left_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.payload.op == OP_LOAD_B) right_mem[req.payload.index] <= req.payload.value;
    if (adv) b_q <= right_mem[b_ptr];
  end

  // stage 1 tag travels with the read data
  logic s1_valid;
  tag_t s1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s1_tag <= tag0;
  end

  // stage 2 product
  logic                     s2_valid;
  tag_t                     s2_tag;
  logic signed [PROD_W-1:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_tag  <= s1_tag;
      s2_prod <= a_q * b_q;
    end
  end

  // accumulate and load the output register
  logic signed [SUM_W-1:0] acc, acc_next;

  assign acc_next = (s2_tag.first ? SUM_W'(0) : acc) + SUM_W'(s2_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= s2_valid && s2_tag.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid) begin
      acc <= acc_next;
      if (s2_tag.last_k) begin
        res_q.result      <= s2_tag.err ? SUM_W'(0) : acc_next;
        res_q.row         <= s2_tag.row;
        res_q.col         <= s2_tag.col;
        res_q.last        <= s2_tag.last;
        res_q.shape_error <= s2_tag.err;
      end
    end
  end

  assign res.valid   = res_valid;
  assign res.payload = res_q;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload.shape_error |-> res.payload.result == '0)
    else $error("shape error result not zero");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.payload.op == OP_RUN |=> state == ST_RUN)
    else $error("run request did not start the sequencer");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN && adv && last_k && last_elem |=> state == ST_IDLE)
    else $error("sequencer did not return to idle after final term");

  a_issue_tracked: assert property (@(posedge clk) disable iff (rst)
    issue |=> s1_valid)
    else $error("issued term lost before stage one");
`endif

endmodule

// ===== bench/matrix_multiply_core_tb.sv =====
`timescale 1ns / 1ps

module matrix_multiply_core_tb;
  import mm_pkg::*;

  localparam int MAX_DIM = DEFAULT_MAX_DIM;
  localparam int ITEMS = 280;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES = 24;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  mm_stream_if #(.payload_t(req_t)) req_ch ();
  mm_stream_if #(.payload_t(res_t)) res_ch ();

  matrix_multiply_core uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int errors = 0;
  int sent_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  int quiet_cycles = 0;

  // product elements still owed by the block, oldest first
  res_t expected_elems[$];

  // shadow of the dimension registers and element stores
  logic [DIM_W-1:0] dim_rows_a = 4'd8;
  logic [DIM_W-1:0] dim_inner_a = 4'd8;
  logic [DIM_W-1:0] dim_rows_b = 4'd8;
  logic [DIM_W-1:0] dim_cols_b = 4'd8;
  logic signed [ELEM_W-1:0] left_mem [STORE_DEPTH];
  logic signed [ELEM_W-1:0] right_mem [STORE_DEPTH];

  // what the stimulus has configured and loaded so far
  logic [DIM_W-1:0] shape_set [4];
  bit a_loaded [STORE_DEPTH];
  bit b_loaded [STORE_DEPTH];

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  // every element of the product, row-major, zeros on a shape mismatch
  function automatic void predict_product();
    int unsigned ra, ia, rb, cb, r, c, k;
    logic mismatch;
    longint acc;
    res_t e;
    ra = eff_dim(dim_rows_a);
    ia = eff_dim(dim_inner_a);
    rb = eff_dim(dim_rows_b);
    cb = eff_dim(dim_cols_b);
    mismatch = (rb != ia);
    for (r = 0; r < ra; r++) begin
      for (c = 0; c < cb; c++) begin
        acc = 0;
        if (!mismatch) begin
          for (k = 0; k < ia; k++) begin
            acc += longint'(left_mem[IDX_W'(r * ia + k)]) *
                   longint'(right_mem[IDX_W'(k * cb + c)]);
          end
        end
        e.result = SUM_W'(acc);
        e.row = POS_W'(r);
        e.col = POS_W'(c);
        e.last = (r == ra - 1) && (c == cb - 1);
        e.shape_error = mismatch;
        expected_elems.push_back(e);
      end
    end
  endfunction

  // track register writes and accepted requests
  always @(posedge clk) begin
    if (!rst && cfg_we) begin
      case (cfg_addr)
        REG_ROWS_A: dim_rows_a = cfg_data;
        REG_INNER_A: dim_inner_a = cfg_data;
        REG_ROWS_B: dim_rows_b = cfg_data;
        REG_COLS_B: dim_cols_b = cfg_data;
        default: ;
      endcase
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      case (req_ch.payload.op)
        OP_LOAD_A: left_mem[req_ch.payload.index] = req_ch.payload.value;
        OP_LOAD_B: right_mem[req_ch.payload.index] = req_ch.payload.value;
        OP_RUN: predict_product();
        default: ;
      endcase
    end
  end

  // compare each delivered element with the oldest expected one
  always @(posedge clk) begin
    res_t exp_e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_elems.size() == 0) begin
        $error("product element with none pending: row %0d col %0d",
               res_ch.payload.row, res_ch.payload.col);
        errors++;
      end else begin
        exp_e = expected_elems.pop_front();
        if (res_ch.payload.result !== exp_e.result) begin
          $error("result: expected %0d, got %0d", exp_e.result, res_ch.payload.result);
          errors++;
        end
        if (res_ch.payload.row !== exp_e.row) begin
          $error("row: expected %0d, got %0d", exp_e.row, res_ch.payload.row);
          errors++;
        end
        if (res_ch.payload.col !== exp_e.col) begin
          $error("col: expected %0d, got %0d", exp_e.col, res_ch.payload.col);
          errors++;
        end
        if (res_ch.payload.last !== exp_e.last) begin
          $error("last: expected %0d, got %0d", exp_e.last, res_ch.payload.last);
          errors++;
        end
        if (res_ch.payload.shape_error !== exp_e.shape_error) begin
          $error("shape_error: expected %0d, got %0d",
                 exp_e.shape_error, res_ch.payload.shape_error);
          errors++;
        end
      end
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one request, return at the edge that accepts it with valid still high
  task automatic send_req(op_t op, logic [IDX_W-1:0] idx, logic signed [ELEM_W-1:0] val);
    req_t item;
    item.op = op;
    item.index = idx;
    item.value = val;
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == OP_LOAD_A) a_loaded[idx] = 1'b1;
    if (op == OP_LOAD_B) b_loaded[idx] = 1'b1;
    if (op != op_t'(OP_RESERVED)) sent_count++;
  endtask

  // drop valid and wait for every pending element, then let the block go quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_elems.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] addr, logic [DIM_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_shape(logic [DIM_W-1:0] ra, logic [DIM_W-1:0] ia,
                           logic [DIM_W-1:0] rb, logic [DIM_W-1:0] cb);
    settle();
    write_reg(REG_ROWS_A, ra);
    write_reg(REG_INNER_A, ia);
    write_reg(REG_ROWS_B, rb);
    write_reg(REG_COLS_B, cb);
    cfg_we <= 1'b0;
    shape_set[REG_ROWS_A] = ra;
    shape_set[REG_INNER_A] = ia;
    shape_set[REG_ROWS_B] = rb;
    shape_set[REG_COLS_B] = cb;
  endtask

  // load any element the next product reads that was never loaded
  task automatic fill_operands();
    int unsigned ra, ia, rb, cb, i, j;
    logic [IDX_W-1:0] pos;
    ra = eff_dim(shape_set[REG_ROWS_A]);
    ia = eff_dim(shape_set[REG_INNER_A]);
    rb = eff_dim(shape_set[REG_ROWS_B]);
    cb = eff_dim(shape_set[REG_COLS_B]);
    if (rb != ia) return;
    for (i = 0; i < ra; i++) begin
      for (j = 0; j < ia; j++) begin
        pos = IDX_W'(i * ia + j);
        if (!a_loaded[pos]) send_req(OP_LOAD_A, pos, ELEM_W'($urandom));
      end
    end
    for (i = 0; i < ia; i++) begin
      for (j = 0; j < cb; j++) begin
        pos = IDX_W'(i * cb + j);
        if (!b_loaded[pos]) send_req(OP_LOAD_B, pos, ELEM_W'($urandom));
      end
    end
  endtask

  task automatic run_product();
    fill_operands();
    send_req(OP_RUN, IDX_W'($urandom_range(63)), ELEM_W'($urandom));
  endtask

  // mostly small sizes, sometimes larger ones up to the largest, zero or out of range
  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return DIM_W'($urandom_range(3, 1));
    if (p < 85) return DIM_W'($urandom_range(8, 4));
    if (p < 92) return '0;
    return DIM_W'($urandom_range(15, 9));
  endfunction

  // a row count for B that agrees with the given inner size, aliases included
  function automatic logic [DIM_W-1:0] matching_dim(logic [DIM_W-1:0] ia);
    if (eff_dim(ia) == 1) return DIM_W'($urandom_range(1));
    if (eff_dim(ia) == MAX_DIM) return DIM_W'($urandom_range(15, 8));
    return ia;
  endfunction

  // 2x2 product over the element extremes, top index and the unused opcode
  task automatic test_small_product();
    set_shape(4'd2, 4'd2, 4'd2, 4'd2);
    send_req(OP_LOAD_A, 6'd0, 16'sh8000);
    send_req(OP_LOAD_A, 6'd1, 16'sh7fff);
    send_req(OP_LOAD_A, 6'd2, 16'sh0100);
    send_req(OP_LOAD_A, 6'd3, 16'shffff);
    send_req(OP_LOAD_B, 6'd0, 16'sh8000);
    send_req(OP_LOAD_B, 6'd1, 16'sh7fff);
    send_req(OP_LOAD_B, 6'd2, 16'sh8000);
    send_req(OP_LOAD_B, 6'd3, 16'sh0000);
    send_req(OP_LOAD_A, 6'd63, 16'sh5a5a);
    send_req(OP_LOAD_B, 6'd63, 16'sha5a5);
    send_req(op_t'(OP_RESERVED), 6'd63, 16'shffff);
    send_req(OP_RUN, 6'd0, 16'sh0000);
  endtask

  // zero and oversized registers as aliases, and inner size mismatches
  task automatic test_shape_rules();
    set_shape(4'd0, 4'd1, 4'd0, 4'd15);
    run_product();
    set_shape(4'd3, 4'd2, 4'd3, 4'd1);
    run_product();
    set_shape(4'd1, 4'd9, 4'd8, 4'd1);
    run_product();
    set_shape(4'd9, 4'd3, 4'd4, 4'd2);
    run_product();
    set_shape(4'd0, 4'd0, 4'd1, 4'd0);
    run_product();
  endtask

  // largest possible sum: eight terms of the most negative element squared
  task automatic test_peak_sum();
    int i;
    set_shape(4'd1, 4'd8, 4'd8, 4'd1);
    for (i = 0; i < 8; i++) begin
      send_req(OP_LOAD_A, IDX_W'(i), 16'sh8000);
      send_req(OP_LOAD_B, IDX_W'(i), 16'sh8000);
    end
    send_req(OP_RUN, 6'd0, 16'sh0000);
  endtask

  // long result hold-off while requests keep coming, then a full drain
  task automatic test_backpressure();
    int i;
    idle_pct = 0;
    stall_pct = 0;
    set_shape(4'd2, 4'd3, 4'd3, 4'd2);
    fill_operands();
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 4; i++) begin
      run_product();
      send_req(OP_LOAD_A, IDX_W'($urandom_range(5)), ELEM_W'($urandom));
    end
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_elems.size() != 0);
    send_req(OP_LOAD_B, IDX_W'($urandom_range(5)), ELEM_W'($urandom));
    run_product();
  endtask

  // random shapes and request mixes under each idling pattern
  task automatic test_random_traffic();
    int phase, n;
    int unsigned p;
    logic [DIM_W-1:0] ra, ia, rb, cb;
    phase = 0;
    while (phase < 4 || sent_count < ITEMS) begin
      case (phase % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 45; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 45; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      ra = pick_dim();
      ia = pick_dim();
      cb = pick_dim();
      rb = ($urandom_range(99) < 75) ? matching_dim(ia) : pick_dim();
      set_shape(ra, ia, rb, cb);
      for (n = 0; n < 30; n++) begin
        p = $urandom_range(99);
        if (p < 50) begin
          send_req($urandom_range(1) ? OP_LOAD_B : OP_LOAD_A,
                   IDX_W'($urandom_range(63)), ELEM_W'($urandom));
        end else if (p < 55) begin
          send_req(op_t'(OP_RESERVED), IDX_W'($urandom_range(63)), ELEM_W'($urandom));
        end else begin
          run_product();
        end
      end
      phase++;
    end
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.payload <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_small_product();
    test_shape_rules();
    test_peak_sum();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (END_CYCLES) @(posedge clk);
    if (errors == 0 && expected_elems.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mm_pkg.sv
design/mm_stream_if.sv
design/matrix_multiply_core.sv
bench/matrix_multiply_core_tb.sv
